// ===== sv/lp_distance_knn_scan_assert.svh =====
// assertion macros for the knn scan block
`ifndef LP_DISTANCE_KNN_SCAN_ASSERT_SVH
`define LP_DISTANCE_KNN_SCAN_ASSERT_SVH
`ifndef SYNTH
`define KNN_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define KNN_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define KNN_ASSERT_IMP(lbl, clk, rstn, a, c)
`define KNN_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== sv/lpknn_pkg.sv =====
`default_nettype none
package lpknn_pkg;
    localparam int K_MAX   = 16;
    localparam int DIM_MAX = 1024;
    localparam int SUM_W  = 48;
    localparam int DIST_W = 40;
    localparam int ID_W   = 32;
    localparam logic [1:0] NORM_L05 = 2'd0;
    localparam logic [1:0] NORM_L1  = 2'd1;
    localparam logic [1:0] NORM_L2  = 2'd2;
    localparam logic [0:0] REG_NORM  = 1'd0;
    localparam logic [0:0] REG_COUNT = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_ACCUM,
        ST_FINISH,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // controller commands to the datapath
    typedef struct packed {
        logic load_item;
        logic start_term;
        logic accum;
        logic start_finish;
        logic do_insert;
        logic emit_load;
        logic emit_clear;
    } cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic sqrt_busy;
        logic item_eov;
        logic item_eos;
        logic emit_last;
    } sts_t;
endpackage
`default_nettype wire

// ===== sv/lp_distance_knn_scan.sv =====
// per coordinate: capture, term, accumulate; l0.5 also waits for the 24-step root and a settle step
// vector end: l1/l0.5 finish, then insert; l2 finishes with the 24-step root before the insert
// scan end then delivers k results, one per cycle while out_ready stays high
// one request in flight at a time; the shared bit-serial root sets the l0.5/l2 rate
// rst_n clears control, list and config to norm l2, k of 16; no clearing pass
`default_nettype none
module lp_distance_knn_scan
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [4:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] query_value,
    input  wire logic signed [15:0] data_value,
    input  wire logic               end_of_vector,
    input  wire logic               end_of_scan,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              rank,
    output logic [31:0]             neighbor_id,
    output logic [39:0]             distance,
    output logic                    last_result
);
    lpknn_pkg::cmd_t cmd;
    lpknn_pkg::sts_t sts;
    logic [1:0] norm_shadow_reg;

    // copy of the norm code for the controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_shadow_reg <= lpknn_pkg::NORM_L2;
        else if (cfg_we && cfg_index == lpknn_pkg::REG_NORM)
            norm_shadow_reg <= cfg_data[1:0];
    end

    lpknn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .norm_mode (norm_shadow_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpknn_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_index),
        .cfg_data      (cfg_data),
        .query_value   (query_value),
        .data_value    (data_value),
        .end_of_vector (end_of_vector),
        .end_of_scan   (end_of_scan),
        .rank          (rank),
        .neighbor_id   (neighbor_id),
        .distance      (distance),
        .last_result   (last_result)
    );
endmodule
`default_nettype wire

// ===== sv/lpknn_isqrt.sv =====
`default_nettype none
// iterative integer square root, one result bit per cycle
module lpknn_isqrt
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] radicand,
    output logic             busy,
    output logic [23:0]      root
);
    logic [47:0] rad_reg, rad_next;
    logic [25:0] rem_reg, rem_next;
    logic [23:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [25:0] rem_sh;
    logic [25:0] trial;

    // restoring step on two radicand bits, msb pair first
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh = {rem_reg[23:0], rad_reg[47:46]};
        trial  = {root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd23;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[45:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[22:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== sv/lpknn_datapath.sv =====
`default_nettype none
`include "lp_distance_knn_scan_assert.svh"
module lpknn_datapath
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lpknn_pkg::cmd_t     cmd,
    output lpknn_pkg::sts_t          sts,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_idx,
    input  wire logic [4:0]          cfg_data,
    input  wire logic signed [15:0]  query_value,
    input  wire logic signed [15:0]  data_value,
    input  wire logic                end_of_vector,
    input  wire logic                end_of_scan,
    output logic [3:0]               rank,
    output logic [31:0]              neighbor_id,
    output logic [39:0]              distance,
    output logic                     last_result
);
    localparam int K_MAX = lpknn_pkg::K_MAX;
    localparam int KW = $clog2(K_MAX + 1);
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam logic [47:0] SUM_MAX = {48{1'b1}};
    localparam logic [39:0] DIST_MAX = {40{1'b1}};

    logic [1:0]  norm_reg;
    logic [4:0]  count_reg;
    logic [16:0] mag_reg;
    logic        eov_reg, eos_reg;
    logic [47:0] term_reg, sum_reg, sum_next;
    logic [39:0] dist_reg;
    logic [31:0] vcnt_reg;
    logic [KW-1:0] fill_reg, fill_next;
    logic [IW-1:0] eidx_reg;
    logic [39:0] bd_reg [K_MAX];
    logic [31:0] bi_reg [K_MAX];
    logic [47:0] sq_in;
    logic        sq_start, sq_busy;
    logic [23:0] sq_root;
    logic [KW-1:0] k_eff, n_eff;
    logic [47:0] term_eff;
    logic [48:0] sum_add;
    logic [23:0] l05_base;
    logic [47:0] l05_prod;
    logic [47:0] l05_sq;
    logic [39:0] dist_eff;
    logic        do_ins;
    logic [32:0] mag_sq;

    // effective k from the count register
    always_comb
    begin
        if (count_reg == 5'd0)
            k_eff = KW'(1);
        else if ({27'd0, count_reg} > 32'(K_MAX))
            k_eff = KW'(K_MAX);
        else
            k_eff = KW'(count_reg);
        n_eff = (fill_reg < k_eff) ? fill_reg : k_eff;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg  <= lpknn_pkg::NORM_L2;
            count_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == lpknn_pkg::REG_NORM)
                norm_reg <= cfg_data[1:0];
            else
                count_reg <= cfg_data;
        end
    end

    // shared square root: term for l0.5, finish for l2
    assign sq_start = (cmd.start_term && norm_reg == lpknn_pkg::NORM_L05) ||
                      (cmd.start_finish && norm_reg != lpknn_pkg::NORM_L05
                      && norm_reg != lpknn_pkg::NORM_L1);
    assign sq_in = cmd.start_term ? {23'd0, mag_reg, 8'd0} : sum_reg;
    lpknn_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    assign mag_sq   = 33'(mag_reg) * 33'(mag_reg);
    assign l05_base = sum_reg[23:0];
    assign l05_prod = 48'(l05_base) * 48'(l05_base);
    assign l05_sq   = l05_prod >> 8;
    // l0.5 term is the root itself, held once the root is done
    assign term_eff = (norm_reg == lpknn_pkg::NORM_L05) ? 48'(sq_root) : term_reg;
    assign sum_add  = {1'b0, sum_reg} + {1'b0, term_eff};
    // l2 distance is the finished root
    assign dist_eff = (norm_reg == lpknn_pkg::NORM_L05 || norm_reg == lpknn_pkg::NORM_L1) ?
                      dist_reg : 40'(sq_root);

    // item capture, term and finished distance
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mag_reg <= (data_value >= query_value) ?
                17'({data_value[15], data_value} - {query_value[15], query_value}) :
                17'({query_value[15], query_value} - {data_value[15], data_value});
            eov_reg <= end_of_vector;
            eos_reg <= end_of_scan;
        end
        if (cmd.start_term)
        begin
            if (norm_reg == lpknn_pkg::NORM_L1)
                term_reg <= 48'(mag_reg);
            else
                term_reg <= 48'(mag_sq);
        end
        if (cmd.start_finish)
        begin
            if (norm_reg == lpknn_pkg::NORM_L1)
                dist_reg <= (sum_reg > 48'(DIST_MAX)) ? DIST_MAX : sum_reg[39:0];
            else if (norm_reg == lpknn_pkg::NORM_L05)
                dist_reg <= (sum_reg[47:24] != 24'd0 || l05_sq > 48'(DIST_MAX)) ?
                    DIST_MAX : l05_sq[39:0];
        end
    end

    // saturating accumulator, cleared on insert
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.accum)
            sum_next = sum_add[48] ? SUM_MAX : sum_add[47:0];
        else if (cmd.do_insert)
            sum_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    // insertion into the sorted list, one shift network over all slots
    assign do_ins = cmd.do_insert && !(n_eff == k_eff &&
                    dist_eff >= bd_reg[IW'(k_eff - KW'(1))]);

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.emit_clear)
            fill_next = '0;
        else if (do_ins)
            fill_next = (n_eff < k_eff) ? n_eff + KW'(1) : k_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            vcnt_reg <= '0;
            eidx_reg <= '0;
            for (int i = 0; i < K_MAX; i++)
            begin
                bd_reg[i] <= DIST_MAX;
                bi_reg[i] <= '0;
            end
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.emit_clear)
                vcnt_reg <= '0;
            else if (cmd.do_insert)
                vcnt_reg <= vcnt_reg + 32'd1;
            if (cmd.emit_clear)
                eidx_reg <= '0;
            else if (cmd.emit_load)
                eidx_reg <= eidx_reg + IW'(1);
            if (cmd.emit_clear)
            begin
                for (int i = 0; i < K_MAX; i++)
                begin
                    bd_reg[i] <= DIST_MAX;
                    bi_reg[i] <= '0;
                end
            end
            else if (do_ins)
            begin
                for (int i = 0; i < K_MAX; i++)
                begin
                    if (KW'(i) <= ((n_eff < k_eff) ? n_eff : k_eff - KW'(1)))
                    begin
                        if (i > 0 && bd_reg[(i > 0) ? i - 1 : 0] > dist_eff)
                        begin
                            bd_reg[i] <= bd_reg[(i > 0) ? i - 1 : 0];
                            bi_reg[i] <= bi_reg[(i > 0) ? i - 1 : 0];
                        end
                        else if (i == 0 || !(bd_reg[(i > 0) ? i - 1 : 0] > dist_eff))
                        begin
                            if (bd_reg[i] > dist_eff || KW'(i) == ((n_eff < k_eff) ?
                                n_eff : k_eff - KW'(1)))
                            begin
                                bd_reg[i] <= dist_eff;
                                bi_reg[i] <= vcnt_reg + 32'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            rank        <= 4'(eidx_reg);
            neighbor_id <= (KW'(eidx_reg) < n_eff) ? bi_reg[eidx_reg] : 32'd0;
            distance    <= (KW'(eidx_reg) < n_eff) ? bd_reg[eidx_reg] : DIST_MAX;
            last_result <= (KW'(eidx_reg) + KW'(1) == k_eff);
        end
    end

    assign sts.sqrt_busy = sq_busy;
    assign sts.item_eov  = eov_reg;
    assign sts.item_eos  = eos_reg;
    assign sts.emit_last = (KW'(eidx_reg) + KW'(1) == k_eff);

    `KNN_ASSERT_IMP(a_fill_le_k, clk, rst_n, 1'b1, fill_reg <= KW'(K_MAX))
    `KNN_ASSERT_NXT(a_clear_fill, clk, rst_n, cmd.emit_clear, fill_reg == '0)
    `KNN_ASSERT_IMP(a_no_ins_emit, clk, rst_n, cmd.do_insert, !cmd.emit_load)
endmodule
`default_nettype wire

// ===== sv/lpknn_ctrl.sv =====
`default_nettype none
`include "lp_distance_knn_scan_assert.svh"
module lpknn_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire logic [1:0]       norm_mode,
    input  wire lpknn_pkg::sts_t  sts,
    output lpknn_pkg::cmd_t       cmd
);
    lpknn_pkg::state_t state_reg, state_next;
    logic ov_reg, ov_next;
    logic fin_reg, fin_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (out_valid && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            lpknn_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = lpknn_pkg::ST_TERM;
                end
            end
            lpknn_pkg::ST_TERM:
            begin
                cmd.start_term = 1'b1;
                state_next = lpknn_pkg::ST_ACCUM;
            end
            lpknn_pkg::ST_ACCUM:
            begin
                if (norm_mode == lpknn_pkg::NORM_L05 && (sts.sqrt_busy || !fin_reg))
                begin
                    fin_next = !sts.sqrt_busy;
                end
                else
                begin
                    fin_next = 1'b0;
                    if (norm_mode == lpknn_pkg::NORM_L05)
                        cmd.accum = 1'b1;
                    else
                        cmd.accum = 1'b1;
                    if (sts.item_eov || sts.item_eos)
                        state_next = lpknn_pkg::ST_FINISH;
                    else
                        state_next = lpknn_pkg::ST_IDLE;
                end
            end
            lpknn_pkg::ST_FINISH:
            begin
                if (!fin_reg)
                begin
                    cmd.start_finish = 1'b1;
                    fin_next = 1'b1;
                end
                else if (!sts.sqrt_busy)
                begin
                    fin_next = 1'b0;
                    cmd.do_insert = 1'b1;
                    state_next = sts.item_eos ? lpknn_pkg::ST_EMIT : lpknn_pkg::ST_IDLE;
                end
            end
            lpknn_pkg::ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.emit_load = 1'b1;
                    ov_next = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.emit_clear = 1'b1;
                        state_next = lpknn_pkg::ST_IDLE;
                    end
                end
            end
            default:
                state_next = lpknn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpknn_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            fin_reg   <= fin_next;
        end
    end

    assign out_valid = ov_reg;

    `KNN_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == lpknn_pkg::ST_IDLE)
    `KNN_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load_item, cmd.start_term,
        cmd.accum, cmd.start_finish, cmd.do_insert, cmd.emit_load}))
    `KNN_ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit_load, out_valid)
endmodule
`default_nettype wire
